### sv/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, widths and codes for the sparse cluster accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
   localparam int CL_W          = 6;
   localparam int KEY_W         = 32;
   localparam int VAL_W         = 32;
   localparam int CNT_W         = 32;
   localparam int SUM_W         = 48;
   localparam int DVS_W         = CNT_W + 1;
   localparam int DIV_CW        = $clog2(SUM_W);

   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_REMOVE = 3'd1;
   localparam logic [2:0] REQ_DECAY  = 3'd2;
   localparam logic [2:0] REQ_MADD   = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NF    = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_DIV0  = 2'd3;

   typedef struct packed {
      logic [2:0]              req_type;
      logic [CL_W-1:0]         cluster;
      logic [KEY_W-1:0]        feature_key;
      logic signed [VAL_W-1:0] feature_value;
      logic [CNT_W-1:0]        divisor_count;
      logic [TABLE_AW-1:0]     slot;
      logic                    last_in_sample;
   } request_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    new_entry;
      logic                    sample_added;
      logic                    entry_valid;
      logic [CL_W-1:0]         entry_cluster;
      logic [KEY_W-1:0]        entry_key;
      logic signed [SUM_W-1:0] entry_mean;
      logic [CNT_W-1:0]        entry_count;
   } response_type;

   typedef struct packed {
      logic                    valid;
      logic [CL_W-1:0]         cluster;
      logic [KEY_W-1:0]        key;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
   } entry_type;

endpackage

`default_nettype wire

### sv/sparse_cluster_accumulator.sv
// ----------------------------------------------------------------------------
// sparse_cluster_accumulator
// Associative table of (cluster, feature key) -> saturating sum and count.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready, one result per request leaves on
// rsp_valid/rsp_ready through an output register.
// The table is a synchronous memory of 1024 entries with one read and one
// write port; add, minibatch add and remove scan it linearly, stopping at the
// first hit, decay scans every slot and read slot reads one slot directly.
// Minibatch add runs a divide ahead of the scan; decay runs one divide for
// each entry of the cluster; read slot adds a divide for the mean.
// One request at a time; the next one can be accepted in the cycle the
// result appears. Throughput is set by the memory scan and the bit-serial
// divider (one quotient bit per cycle).
// After reset, valid bits are cleared one slot per cycle across all 1024
// slots, with req_ready low.
// A stalled receiver holds the result in the output register; the block
// finishes the next request and then waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_cluster_accumulator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sca_pkg::request_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sca_pkg::response_type rsp_data
);
   import sca_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_DIVA   = 4'd3;
   localparam logic [3:0] S_RD     = 4'd4;
   localparam logic [3:0] S_CHK    = 4'd5;
   localparam logic [3:0] S_DIVW   = 4'd6;
   localparam logic [3:0] S_RDSLOT = 4'd7;
   localparam logic [3:0] S_RDCHK  = 4'd8;
   localparam logic [3:0] S_RDDIV  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   entry_type mem [TABLE_ENTRIES];
   entry_type mem_rd_ff;
   logic                mem_we;
   logic [TABLE_AW-1:0] mem_wa;
   logic [TABLE_AW-1:0] mem_ra;
   entry_type           mem_wd;

   logic [3:0]              state_ff, state_in;
   logic [TABLE_AW-1:0]     idx_ff, idx_in;
   request_type             req_ff, req_in;
   response_type            res_ff, res_in;
   logic signed [SUM_W-1:0] amt_ff, amt_in;
   entry_type               ent_ff, ent_in;
   logic                    free_ok_ff, free_ok_in;
   logic [TABLE_AW-1:0]     free_idx_ff, free_idx_in;
   logic                    seen_ff, seen_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   response_type            rsp_ff, rsp_in;

   logic                    div_start;
   logic signed [SUM_W-1:0] div_dvd;
   logic [DVS_W-1:0]        div_dvs;
   logic                    div_done;
   logic signed [SUM_W-1:0] div_quo;

   logic                    hit;
   logic                    last_idx;
   logic                    nseen;
   logic [DVS_W-1:0]        np1;
   logic signed [SUM_W-1:0] val_ext;
   logic [CNT_W-1:0]        cnt_dec;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [SUM_W+1:0] s;
      s = {{2{a[SUM_W-1]}}, a} + {{2{b[SUM_W-1]}}, b};
      if (s[SUM_W+1:SUM_W-1] == 3'b000 || s[SUM_W+1:SUM_W-1] == 3'b111) begin
         return s[SUM_W-1:0];
      end else if (s[SUM_W+1]) begin
         return {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SUM_W-1){1'b1}}};
      end
   endfunction

   sca_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   assign mem_ra   = (state_ff == S_RDSLOT) ? req_ff.slot : idx_ff;
   assign np1      = {1'b0, req_ff.divisor_count} + DVS_W'(1);
   assign val_ext  = SUM_W'(req_ff.feature_value);
   assign hit      = mem_rd_ff.valid && mem_rd_ff.cluster == req_ff.cluster
                     && mem_rd_ff.key == req_ff.feature_key;
   assign last_idx = idx_ff == TABLE_AW'(TABLE_ENTRIES-1);
   assign cnt_dec  = (mem_rd_ff.count != '0) ? mem_rd_ff.count - 1'b1 : '0;
   assign nseen    = seen_ff | res_ff.new_entry;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      amt_in       = amt_ff;
      ent_in       = ent_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = mem_rd_ff;
      div_start    = 1'b0;
      div_dvd      = val_ext;
      div_dvs      = np1;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = '0;
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_in     = '0;
            idx_in     = '0;
            free_ok_in = 1'b0;
            amt_in     = val_ext;
            unique case (req_ff.req_type) inside
               REQ_ADD, REQ_REMOVE, REQ_DECAY: state_in = S_RD;
               REQ_MADD: begin
                  div_start = 1'b1;
                  state_in  = S_DIVA;
               end
               REQ_READ: begin
                  if (req_ff.divisor_count == '0) begin
                     res_in.status = ST_DIV0;
                  end
                  state_in = S_RDSLOT;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DIVA: begin
            if (div_done) begin
               amt_in   = div_quo;
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            unique case (req_ff.req_type) inside
               REQ_ADD, REQ_MADD: begin
                  if (hit) begin
                     mem_we     = 1'b1;
                     mem_wd.sum = sat_add(mem_rd_ff.sum, amt_ff);
                     if (req_ff.req_type == REQ_ADD && mem_rd_ff.count != '1) begin
                        mem_wd.count = mem_rd_ff.count + 1'b1;
                     end
                     state_in = S_DONE;
                  end else begin
                     if (!mem_rd_ff.valid && !free_ok_ff) begin
                        free_ok_in  = 1'b1;
                        free_idx_in = idx_ff;
                     end
                     if (last_idx) begin
                        if (free_ok_ff || !mem_rd_ff.valid) begin
                           mem_we           = 1'b1;
                           mem_wa           = free_ok_ff ? free_idx_ff : idx_ff;
                           mem_wd.valid     = 1'b1;
                           mem_wd.cluster   = req_ff.cluster;
                           mem_wd.key       = req_ff.feature_key;
                           mem_wd.sum       = amt_ff;
                           mem_wd.count     = CNT_W'(1);
                           res_in.new_entry = 1'b1;
                        end else begin
                           res_in.status = ST_FULL;
                        end
                        state_in = S_DONE;
                     end else begin
                        idx_in   = idx_ff + 1'b1;
                        state_in = S_RD;
                     end
                  end
               end
               REQ_REMOVE: begin
                  if (hit) begin
                     mem_we       = 1'b1;
                     mem_wd.sum   = sat_add(mem_rd_ff.sum, -val_ext);
                     mem_wd.count = cnt_dec;
                     mem_wd.valid = cnt_dec != '0;
                     state_in     = S_DONE;
                  end else if (last_idx) begin
                     res_in.status = ST_NF;
                     state_in      = S_DONE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               REQ_DECAY: begin
                  if (mem_rd_ff.valid && mem_rd_ff.cluster == req_ff.cluster) begin
                     ent_in    = mem_rd_ff;
                     div_start = 1'b1;
                     div_dvd   = mem_rd_ff.sum;
                     state_in  = S_DIVW;
                  end else if (last_idx) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DIVW: begin
            if (div_done) begin
               mem_we     = 1'b1;
               mem_wd     = ent_ff;
               mem_wd.sum = ent_ff.sum - div_quo;
               if (last_idx) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_RDSLOT: state_in = S_RDCHK;
         S_RDCHK: begin
            if (mem_rd_ff.valid) begin
               res_in.entry_valid   = 1'b1;
               res_in.entry_cluster = mem_rd_ff.cluster;
               res_in.entry_key     = mem_rd_ff.key;
               res_in.entry_count   = mem_rd_ff.count;
               if (req_ff.divisor_count != '0) begin
                  div_start = 1'b1;
                  div_dvd   = mem_rd_ff.sum;
                  div_dvs   = {1'b0, req_ff.divisor_count};
                  state_in  = S_RDDIV;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_RDDIV: begin
            if (div_done) begin
               res_in.entry_mean = div_quo;
               state_in          = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               if (req_ff.req_type == REQ_ADD || req_ff.req_type == REQ_MADD) begin
                  if (req_ff.last_in_sample) begin
                     rsp_in.sample_added = nseen;
                     seen_in             = 1'b0;
                  end else begin
                     seen_in = nseen;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         free_ok_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         free_ok_ff   <= free_ok_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      amt_ff      <= amt_in;
      ent_ff      <= ent_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### sv/sca_divider.sv
// ----------------------------------------------------------------------------
// sca_divider
// Restoring signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [sca_pkg::SUM_W-1:0] dividend,
   input  logic [sca_pkg::DVS_W-1:0]        divisor,
   output logic                             done,
   output logic signed [sca_pkg::SUM_W-1:0] quotient
);
   import sca_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(SUM_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

`default_nettype wire

### sv/sca_checker.sv
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks for the sparse cluster accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input sca_pkg::response_type rsp_data
);
   import sca_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

   a_new_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_entry |-> rsp_data.status == ST_OK
                                          && !rsp_data.entry_valid)
      else $error("new entry with bad status");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |-> rsp_data.entry_key == '0
         && rsp_data.entry_mean == '0 && rsp_data.entry_count == '0)
      else $error("entry fields set without a valid entry");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind sparse_cluster_accumulator sca_checker u_sca_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
